// ===== hw/rtl/polyphase_rational_resampler_assert.svh =====
// assertion macros for the resampler checker
// no dependencies
`ifndef POLYPHASE_RATIONAL_RESAMPLER_ASSERT_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_ASSERT_SVH
`define PRR_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define PRR_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/prr_pkg.sv =====
// shared types and constants for the polyphase resampler
// no dependencies
package prr_pkg;
  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_MAC, ST_DRAIN, ST_FINISH, ST_OUT
  } state_t;
  localparam logic [1:0] REG_INTERP = 2'd0;
  localparam logic [1:0] REG_DECIM  = 2'd1;
  localparam logic [1:0] REG_TAPS   = 2'd2;
  localparam logic [1:0] REG_CPLX   = 2'd3;
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TAP    = 1'b1;
  localparam int MAX_RESULTS = 16;
  typedef struct packed {
    logic clear_step;
    logic start_out;
    logic mac_step;
    logic acc_clear;
    logic finish;
  } cmd_t;
  typedef struct packed {
    logic clear_done;
    logic mac_last;
    logic more;
    logic phase_ok;
    logic reduce_busy;
  } stat_t;
endpackage

// ===== hw/rtl/prr_if.sv =====
// valid/ready stream interface
// no dependencies
interface prr_if #(parameter int W = 1) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/prr_ram.sv =====
// generic simple dual port ram with registered read
// no dependencies
module prr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/prr_ctrl.sv =====
// controller state machine for the resampler
// depends on prr_pkg
module prr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_cmd,
  input  logic            skip_pending,
  input  logic            out_ready,
  input  prr_pkg::stat_t  stat,
  output logic            in_ready,
  output logic            out_valid,
  output prr_pkg::cmd_t   cmd
);
  prr_pkg::state_t state, state_next;
  logic [1:0] drain, drain_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prr_pkg::ST_CLEAR;
      drain <= '0;
    end else begin
      state <= state_next;
      drain <= drain_next;
    end
  end

  always_comb begin
    state_next = state;
    drain_next = drain;
    case (state)
      prr_pkg::ST_CLEAR: if (stat.clear_done) state_next = prr_pkg::ST_IDLE;
      prr_pkg::ST_IDLE:
        if (in_valid && stat.phase_ok && in_cmd == prr_pkg::CMD_SAMPLE && !skip_pending)
          state_next = prr_pkg::ST_MAC;
      prr_pkg::ST_MAC:
        if (stat.mac_last) begin
          state_next = prr_pkg::ST_DRAIN;
          drain_next = 2'd0;
        end
      prr_pkg::ST_DRAIN: begin
        if (drain != 2'd2) drain_next = drain + 2'd1;
        else if (!stat.reduce_busy) state_next = prr_pkg::ST_FINISH;
      end
      prr_pkg::ST_FINISH: state_next = prr_pkg::ST_OUT;
      prr_pkg::ST_OUT:
        if (out_ready) state_next = stat.more ? prr_pkg::ST_MAC : prr_pkg::ST_IDLE;
      default: state_next = prr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      prr_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      prr_pkg::ST_IDLE: begin
        in_ready = stat.phase_ok;
        cmd.start_out = 1'b1;
        cmd.acc_clear = 1'b1;
      end
      prr_pkg::ST_MAC: cmd.mac_step = 1'b1;
      prr_pkg::ST_FINISH: cmd.finish = 1'b1;
      prr_pkg::ST_OUT: begin
        out_valid = 1'b1;
        cmd.acc_clear = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/prr_dp.sv =====
// datapath: delay line and coefficient rams, shared mac, rounding, phase
// depends on prr_pkg and prr_ram
module prr_dp #(
  parameter int MAX_TAPS = 256,
  parameter int MAX_INTERP = 16,
  parameter int MAX_DECIM = 16,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_xfer,
  input  logic                           in_cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] in_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_im,
  input  logic [7:0]                     in_idx,
  input  logic signed [COEF_WIDTH-1:0]   in_coef,
  input  logic                           out_xfer,
  input  logic [4:0]                     reg_l,
  input  logic [4:0]                     reg_m,
  input  logic [8:0]                     reg_n,
  input  logic                           reg_cplx,
  input  prr_pkg::cmd_t                  cmd,
  output prr_pkg::stat_t                 stat,
  output logic                           skip_pending,
  output logic signed [SAMPLE_WIDTH-1:0] out_re,
  output logic signed [SAMPLE_WIDTH-1:0] out_im,
  output logic                           last_of_run,
  output logic                           saturated
);
  localparam int AW = $clog2(MAX_TAPS);
  localparam int PW = $clog2(MAX_INTERP + 1);
  localparam int DW = $clog2(MAX_DECIM + 1);
  localparam int SW = $clog2(MAX_DECIM + 1);
  localparam int NW = $clog2(MAX_TAPS + 1);
  localparam int PRW = SAMPLE_WIDTH + COEF_WIDTH + PW;
  localparam int ACW = PRW + AW + 1;

  logic [AW-1:0] head, clr_addr, wptr;
  logic [NW-1:0] k, j;
  logic [PW-1:0] phase, p, ell;
  logic [DW-1:0] em;
  logic [NW-1:0] nt;
  logic [SW-1:0] skip;
  logic [4:0] cnt;
  logic valid1, valid2, valid3;
  logic clearing;
  logic signed [SAMPLE_WIDTH-1:0] x_re, x_im;
  logic signed [COEF_WIDTH-1:0] c_rd;
  logic signed [PRW-1:0] prod_re, prod_im;
  logic signed [ACW-1:0] acc_re, acc_im;
  logic is_last;

  assign ell = (reg_l == 5'd0) ? PW'(1) : (reg_l > 5'(MAX_INTERP)) ? PW'(MAX_INTERP) : PW'(reg_l);
  assign em = (reg_m == 5'd0) ? DW'(1) : (reg_m > 5'(MAX_DECIM)) ? DW'(MAX_DECIM) : DW'(reg_m);
  assign nt = (reg_n == 9'd0) ? NW'(1) : (reg_n > 9'(MAX_TAPS)) ? NW'(MAX_TAPS) : NW'(reg_n);

  logic push;
  assign push = in_xfer && in_cmd == prr_pkg::CMD_SAMPLE;
  assign wptr = head - AW'(1);

  // delay line as circular buffer, newest at head
  logic dl_we, cf_we;
  logic [AW-1:0] dl_waddr, cf_waddr, dl_raddr, cf_raddr;
  assign dl_we = clearing || push;
  assign dl_waddr = clearing ? clr_addr : wptr;
  assign cf_we = clearing || (in_xfer && in_cmd == prr_pkg::CMD_TAP);
  assign cf_waddr = clearing ? clr_addr : in_idx[AW-1:0];
  assign dl_raddr = head + j[AW-1:0];
  assign cf_raddr = k[AW-1:0];

  prr_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_TAPS)) u_re (
    .clk, .we(dl_we), .waddr(dl_waddr), .wdata(clearing ? '0 : in_re),
    .raddr(dl_raddr), .rdata(x_re));
  prr_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_TAPS)) u_im (
    .clk, .we(dl_we), .waddr(dl_waddr), .wdata(clearing ? '0 : in_im),
    .raddr(dl_raddr), .rdata(x_im));
  prr_ram #(.WIDTH(COEF_WIDTH), .DEPTH(MAX_TAPS)) u_cf (
    .clk, .we(cf_we), .waddr(cf_waddr), .wdata(clearing ? '0 : in_coef),
    .raddr(cf_raddr), .rdata(c_rd));

  assign clearing = cmd.clear_step;
  assign stat.clear_done = clr_addr == AW'(MAX_TAPS - 1);
  logic step_ok;
  assign step_ok = (k < nt) && (j < NW'(MAX_TAPS));
  assign stat.mac_last = !step_ok || ((k + NW'(ell)) >= nt) || (j == NW'(MAX_TAPS - 1));

  // iterative reduction of phase + M by L, runs alongside the mac, drain waits for it
  logic [PW+DW-1:0] rem;
  logic [PW+DW-1:0] wcnt;
  logic reducing;

  logic signed [SAMPLE_WIDTH-1:0] m_re, m_im;
  logic signed [COEF_WIDTH+PW:0] cl;

  function automatic logic [SAMPLE_WIDTH:0] fin(input logic signed [ACW-1:0] a);
    logic signed [ACW-1:0] r;
    logic signed [ACW-1:0] v;
    logic clip;
    r = a + (ACW'(1) <<< (COEF_WIDTH - 2));
    v = r >>> (COEF_WIDTH - 1);
    clip = 1'b0;
    if (v > ACW'((1 <<< (SAMPLE_WIDTH - 1)) - 1)) begin
      v = ACW'((1 <<< (SAMPLE_WIDTH - 1)) - 1); clip = 1'b1;
    end else if (v < -ACW'(1 <<< (SAMPLE_WIDTH - 1))) begin
      v = -ACW'(1 <<< (SAMPLE_WIDTH - 1)); clip = 1'b1;
    end
    return {clip, v[SAMPLE_WIDTH-1:0]};
  endfunction

  logic [SAMPLE_WIDTH:0] f_re, f_im;
  assign f_re = fin(acc_re);
  assign f_im = fin(acc_im);
  assign stat.more = !is_last;
  assign stat.phase_ok = phase < ell;
  assign stat.reduce_busy = reducing;
  assign skip_pending = skip != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      clr_addr <= '0;
      phase <= '0;
      skip <= '0;
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      reducing <= 1'b0;
    end else begin
      if (clearing) clr_addr <= clr_addr + AW'(1);
      if (push) begin
        head <= wptr;
        if (skip != '0) skip <= skip - SW'(1);
      end
      valid1 <= cmd.mac_step && step_ok;
      valid2 <= valid1;
      valid3 <= valid2;
      if (cmd.start_out && push) begin
        rem <= (PW+DW)'(phase) + (PW+DW)'(em);
        wcnt <= '0;
        reducing <= 1'b1;
      end else if (out_xfer && !is_last) begin
        rem <= rem + (PW+DW)'(em);
        wcnt <= '0;
        reducing <= 1'b1;
      end else if (reducing) begin
        if (rem >= (PW+DW)'(ell)) begin
          rem <= rem - (PW+DW)'(ell);
          wcnt <= wcnt + (PW+DW)'(1);
        end else reducing <= 1'b0;
      end
      // phase is brought below L after a factor change before input is taken
      if (out_xfer && is_last) begin
        phase <= rem[PW-1:0];
        skip <= (wcnt != '0) ? SW'(wcnt - (PW+DW)'(1)) : '0;
      end else if (phase >= ell) begin
        phase <= phase - ell;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_out) begin
      p <= phase;
      k <= NW'(phase);
      j <= '0;
      cnt <= '0;
    end else if (out_xfer) begin
      p <= rem[PW-1:0];
      k <= NW'(rem[PW-1:0]);
      j <= '0;
      cnt <= cnt + 5'd1;
    end else if (cmd.mac_step) begin
      k <= k + NW'(ell);
      j <= j + NW'(1);
    end
    cl <= $signed({1'b0, ell}) * c_rd;
    m_re <= x_re;
    m_im <= x_im;
    prod_re <= PRW'(cl) * PRW'(m_re);
    prod_im <= PRW'(cl) * PRW'(m_im);
    if (cmd.acc_clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (valid3) begin
      acc_re <= acc_re + ACW'(prod_re);
      acc_im <= acc_im + ACW'(prod_im);
    end
    if (cmd.finish) begin
      out_re <= f_re[SAMPLE_WIDTH-1:0];
      out_im <= reg_cplx ? f_im[SAMPLE_WIDTH-1:0] : '0;
      saturated <= f_re[SAMPLE_WIDTH] || (reg_cplx && f_im[SAMPLE_WIDTH]);
      is_last <= (wcnt != '0) || (cnt == 5'(prr_pkg::MAX_RESULTS - 1));
      last_of_run <= (wcnt != '0) || (cnt == 5'(prr_pkg::MAX_RESULTS - 1));
    end
  end
endmodule

// ===== hw/rtl/polyphase_rational_resampler.sv =====
// channel    dir  payload
// in         sink command, sample_re, sample_im, tap_index, tap_value
// out        src  out_re, out_im, last_of_run, saturated
// cfg        in   cfg_we, cfg_index, cfg_data
// a sample is accepted, then per output the mac steps through the taps in its phase,
// followed by the drain, finish and output transfer states
// drain stretches while the phase wrap is still being reduced
// worst case 16 outputs per sample over 256 taps, lengthened by output stalls
// after reset a clearing pass over all MAX_TAPS addresses runs before input is taken
// input waits while a result is computed or held, or the phase is reduced after a factor change
module polyphase_rational_resampler #(
  parameter int MAX_TAPS = 256,
  parameter int MAX_INTERP = 16,
  parameter int MAX_DECIM = 16,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH = 16
) (
  input logic clk,
  input logic rst,
  prr_if.sink   in,
  prr_if.source out,
  input logic       cfg_we,
  input logic [1:0] cfg_index,
  input logic [8:0] cfg_data
);
  logic [4:0] reg_l, reg_m;
  logic [8:0] reg_n;
  logic reg_cplx;
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_l <= 5'd1; reg_m <= 5'd1; reg_n <= 9'd1; reg_cplx <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        prr_pkg::REG_INTERP: reg_l <= cfg_data[4:0];
        prr_pkg::REG_DECIM:  reg_m <= cfg_data[4:0];
        prr_pkg::REG_TAPS:   reg_n <= cfg_data;
        prr_pkg::REG_CPLX:   reg_cplx <= cfg_data[0];
        default: ;
      endcase
    end
  end

  prr_pkg::cmd_t cmd;
  prr_pkg::stat_t stat;
  logic skip_pending;
  logic in_xfer, out_xfer;
  assign in_xfer = in.valid && in.ready;
  assign out_xfer = out.valid && out.ready;

  prr_ctrl u_ctrl (
    .clk, .rst, .in_valid(in.valid), .in_cmd(in.data[0]), .skip_pending,
    .out_ready(out.ready), .stat, .in_ready(in.ready), .out_valid(out.valid), .cmd);

  prr_dp #(.MAX_TAPS(MAX_TAPS), .MAX_INTERP(MAX_INTERP), .MAX_DECIM(MAX_DECIM),
    .SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_dp (
    .clk, .rst, .in_xfer, .in_cmd(in.data[0]),
    .in_re(in.data[SAMPLE_WIDTH:1]), .in_im(in.data[2*SAMPLE_WIDTH:SAMPLE_WIDTH+1]),
    .in_idx(in.data[2*SAMPLE_WIDTH+8:2*SAMPLE_WIDTH+1]),
    .in_coef(in.data[2*SAMPLE_WIDTH+8+COEF_WIDTH:2*SAMPLE_WIDTH+9]),
    .out_xfer, .reg_l, .reg_m, .reg_n, .reg_cplx, .cmd, .stat, .skip_pending,
    .out_re(out.data[SAMPLE_WIDTH-1:0]), .out_im(out.data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .last_of_run(out.data[2*SAMPLE_WIDTH]), .saturated(out.data[2*SAMPLE_WIDTH+1]));
endmodule

// ===== hw/rtl/prr_checker.sv =====
// port level checker for the resampler, bound to the top level
// depends on polyphase_rational_resampler_assert.svh
`include "polyphase_rational_resampler_assert.svh"
module prr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  `PRR_ASSERT_IMPL(no_in_while_out, out_valid, !in_ready)
  `PRR_ASSERT_NEXT(out_holds, out_valid && !out_ready, out_valid)
  `PRR_ASSERT_NEXT(no_out_after_in, in_valid && in_ready, !out_valid)
endmodule

bind polyphase_rational_resampler prr_checker u_chk (
  .clk, .rst, .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready));
